FILE: hw/rtl/sia_pkg.sv
// Shared types, constants and helpers for the slot index allocator.
package sia_pkg;

   localparam int WordBits    = 32;
   localparam int OffBits     = 5;
   localparam int SlotInBits  = 11;
   localparam int GrantBits   = 10;
   localparam int ReqDataBits = 16;
   localparam int RspDataBits = 16;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_wr;
      logic ptr_clear;
      logic scan_rd;
      logic alloc_commit;
      logic free_rd;
      logic free_commit;
      logic res_zero;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic ptr_last;
      logic op_free;
      logic free_in_range;
      logic out_free;
   } dp_sts_type;

   function automatic logic [OffBits-1:0] first_set(input logic [WordBits-1:0] bits);
      logic [OffBits-1:0] pos;
      pos = '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = OffBits'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: hw/rtl/sia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sia_ram #(
   parameter int Width = 32,
   parameter int Depth = 32,
   parameter int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [Width-1:0]    wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [Width-1:0]    rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sia_ctrl.sv
// Controller state machine for the slot index allocator.
module sia_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sia_pkg::dp_sts_type sts,
   output sia_pkg::dp_cmd_type cmd
);

   import sia_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.ptr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.op_free) begin
               if (sts.free_in_range) begin
                  state_in = ST_FREE_RD;
               end else begin
                  cmd.res_zero = 1'b1;
                  state_in     = ST_DONE;
               end
            end else begin
               cmd.ptr_clear = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.ptr_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.alloc_commit = 1'b1;
            state_in         = ST_DONE;
         end
         ST_FREE_RD: begin
            cmd.free_rd = 1'b1;
            state_in    = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            cmd.free_commit = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded while output register busy");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_scan_follows_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.ptr_clear |=> state_ff == ST_SCAN)
      else $error("scan did not start after dispatch");

endmodule

FILE: hw/rtl/sia_dp.sv
// Datapath: used-slot bitmap RAM, search hint, word scan and result registers.
module sia_dp #(
   parameter int Slots = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  sia_pkg::dp_cmd_type cmd,
   output sia_pkg::dp_sts_type sts,
   input  logic [sia_pkg::ReqDataBits-1:0] req_tdata,
   input  logic                req_tuser,
   output logic [sia_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready
);

   import sia_pkg::*;

   localparam int Words    = (Slots + WordBits - 1) / WordBits;
   localparam int AddrBits = (Words > 1) ? $clog2(Words) : 1;
   localparam int IdxBits  = AddrBits + OffBits;
   localparam int HintBits = $clog2(Slots + 1);
   localparam int CmpBits  = IdxBits + 1;
   localparam int TailBits = Slots - (Words - 1) * WordBits;
   localparam logic [WordBits-1:0] TailMask = {WordBits{1'b1}} >> (WordBits - TailBits);
   localparam logic [AddrBits-1:0] LastAddr = AddrBits'(Words - 1);

   // latched request
   logic                  op_ff;
   logic [SlotInBits-1:0] slot_ff;

   logic [AddrBits-1:0] ptr_ff, ptr_in;
   logic                eval_valid_ff;
   logic [AddrBits-1:0] eval_addr_ff;
   logic [HintBits-1:0] hint_ff, hint_in;

   logic                up_found_ff, lo_found_ff;
   logic [IdxBits-1:0]  up_slot_ff, lo_slot_ff;
   logic [WordBits-1:0] up_word_ff, lo_word_ff;

   logic [GrantBits-1:0] res_slot_ff;
   logic                 res_nofree_ff;
   logic                 rsp_valid_ff;
   logic [GrantBits-1:0] rsp_slot_ff;
   logic                 rsp_nofree_ff;

   logic                wr_en;
   logic [AddrBits-1:0] wr_addr, rd_addr;
   logic [WordBits-1:0] wr_data, rd_data;

   logic [AddrBits-1:0] free_addr;
   logic [OffBits-1:0]  free_off;
   logic [CmpBits-1:0]  hint_ext;
   logic [AddrBits:0]   hint_word;
   logic [OffBits-1:0]  hint_off;
   logic [WordBits-1:0] free_bits, ge_mask, up_bits, lo_bits;
   logic                have;
   logic [IdxBits-1:0]  pick_slot;
   logic [WordBits-1:0] pick_word;

   sia_ram #(
      .Width (WordBits),
      .Depth (Words)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign free_addr = AddrBits'(slot_ff[SlotInBits-1:OffBits]);
   assign free_off  = slot_ff[OffBits-1:0];

   assign hint_ext  = CmpBits'(hint_ff);
   assign hint_word = hint_ext[CmpBits-1:OffBits];
   assign hint_off  = hint_ext[OffBits-1:0];

   assign have      = up_found_ff | lo_found_ff;
   assign pick_slot = up_found_ff ? up_slot_ff : lo_slot_ff;
   assign pick_word = up_found_ff ? up_word_ff : lo_word_ff;

   // split the free bits of the word just read around the hint
   always_comb begin
      free_bits = ~rd_data & ((eval_addr_ff == LastAddr) ? TailMask : {WordBits{1'b1}});
      ge_mask   = {WordBits{1'b1}} << hint_off;
      if ({1'b0, eval_addr_ff} > hint_word) begin
         up_bits = free_bits;
         lo_bits = '0;
      end else if ({1'b0, eval_addr_ff} == hint_word) begin
         up_bits = free_bits & ge_mask;
         lo_bits = free_bits & ~ge_mask;
      end else begin
         up_bits = '0;
         lo_bits = free_bits;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_commit && have) begin
         wr_en   = 1'b1;
         wr_addr = pick_slot[IdxBits-1:OffBits];
         wr_data = pick_word | (WordBits'(1) << pick_slot[OffBits-1:0]);
      end else if (cmd.free_commit) begin
         wr_en   = 1'b1;
         wr_addr = free_addr;
         wr_data = rd_data & ~(WordBits'(1) << free_off);
      end
   end

   assign rd_addr = cmd.free_rd ? free_addr : ptr_ff;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
         ptr_in = ptr_ff + AddrBits'(1);
      end
   end

   always_comb begin
      hint_in = hint_ff;
      if (cmd.alloc_commit && have) begin
         hint_in = HintBits'(CmpBits'(pick_slot) + CmpBits'(1));
      end else if (cmd.free_commit && (32'(slot_ff) < 32'(hint_ff))) begin
         hint_in = HintBits'(slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         eval_valid_ff <= 1'b0;
         hint_ff       <= '0;
         up_found_ff   <= 1'b0;
         lo_found_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         eval_valid_ff <= cmd.scan_rd;
         hint_ff       <= hint_in;
         if (cmd.ptr_clear) begin
            up_found_ff <= 1'b0;
            lo_found_ff <= 1'b0;
         end else if (eval_valid_ff) begin
            if (!up_found_ff && (|up_bits)) begin
               up_found_ff <= 1'b1;
            end
            if (!lo_found_ff && (|lo_bits)) begin
               lo_found_ff <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_addr_ff <= ptr_ff;
      if (cmd.load_req) begin
         op_ff   <= req_tuser;
         slot_ff <= req_tdata[SlotInBits-1:0];
      end
      if (eval_valid_ff && !cmd.ptr_clear) begin
         if (!up_found_ff && (|up_bits)) begin
            up_slot_ff <= {eval_addr_ff, first_set(up_bits)};
            up_word_ff <= rd_data;
         end
         if (!lo_found_ff && (|lo_bits)) begin
            lo_slot_ff <= {eval_addr_ff, first_set(lo_bits)};
            lo_word_ff <= rd_data;
         end
      end
      if (cmd.alloc_commit) begin
         res_slot_ff   <= have ? GrantBits'(pick_slot) : '0;
         res_nofree_ff <= !have;
      end else if (cmd.free_commit || cmd.res_zero) begin
         res_slot_ff   <= '0;
         res_nofree_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_nofree_ff <= res_nofree_ff;
      end
   end

   assign sts.ptr_last      = (ptr_ff == LastAddr);
   assign sts.op_free       = op_ff;
   assign sts.free_in_range = (32'(slot_ff) < 32'(Slots));
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataBits'(rsp_slot_ff);
   assign rsp_tuser  = rsp_nofree_ff;

   a_hint_after_grant: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_commit && have) |=> hint_ff != '0)
      else $error("hint not advanced past granted slot");

   a_free_never_raises_hint: assert property (@(posedge clock) disable iff (reset)
      cmd.free_commit |=> hint_ff <= $past(hint_ff))
      else $error("free raised the search hint");

   a_nofree_zero_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nofree_ff) |-> rsp_slot_ff == '0)
      else $error("failed allocate carries a nonzero slot");

endmodule

FILE: hw/rtl/slot_index_allocator.sv
// Top level of the slot index allocator: bitmap slot pool with search hint.
//
//   port group  dir  tdata fields (low bit up)   tuser
//   req_*       in   slot_to_free[10:0], pad     operation (0 alloc, 1 free)
//   rsp_*       out  granted_slot[9:0], pad      no_free
//
// Allocate: dispatch, then a scan of the bitmap RAM at one word per cycle through its
//   single read port, then a decide step that commits the grant.
// Free: read-modify-write of one bitmap word; an out-of-range free goes straight to the result.
// After reset a clearing pass writes zero to every bitmap word; no beat
//   is accepted until it ends.
// One request at a time; the next beat is accepted while a result waits in the
//   output register, and a stalled result holds the block only at its next result.
module slot_index_allocator #(
   parameter int SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // slot_to_free[10:0], zero pad
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // granted_slot[9:0], zero pad
   output logic        rsp_tuser    // no_free
);

   import sia_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sia_dp #(
      .Slots (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

FILE: tb/sv/tb.sv
// Testbench for slot_index_allocator: bitmap slot pool with allocate and free streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sia_pkg::*;

   localparam int SLOTS       = 1024;
   localparam int PERIOD      = 8;
   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;

   localparam bit OP_ALLOC = 1'b0;
   localparam bit OP_FREE  = 1'b1;

   typedef struct packed {
      logic [GrantBits-1:0] slot;
      logic                 no_free;
   } grant_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata;   // slot_to_free[10:0], zero pad
   logic                   req_tuser;   // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RspDataBits-1:0] rsp_tdata;   // granted_slot[9:0], zero pad
   logic                   rsp_tuser;   // no_free

   // mirror of the pool
   bit          slot_used [SLOTS];
   int unsigned next_hint;
   int unsigned used_count;

   grant_type expected_grants [$];
   grant_type checked_grant;
   int        mismatches;
   int        stuck_cycles;
   int        stall_left;
   bit        quiet_tail;

   slot_index_allocator #(.SLOTS(SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic grant_type grant_for_request(input bit op,
                                                   input logic [SlotInBits-1:0] idx);
      grant_type g;
      int        found;
      int        s;
      g = '0;
      found = -1;
      if (op == OP_ALLOC) begin
         for (s = next_hint; s < SLOTS && found < 0; s++) begin
            if (!slot_used[s]) found = s;
         end
         for (s = 0; s < next_hint && found < 0; s++) begin
            if (!slot_used[s]) found = s;
         end
         if (found < 0) begin
            g.no_free = 1'b1;
         end else begin
            slot_used[found] = 1'b1;
            used_count++;
            next_hint = found + 1;
            g.slot = GrantBits'(found);
         end
      end else if (idx < SLOTS) begin
         if (slot_used[idx]) used_count--;
         slot_used[idx] = 1'b0;
         if (idx < next_hint) next_hint = idx;
      end
      return g;
   endfunction

   function automatic int pick_used_slot();
      int s;
      int n;
      s = $urandom_range(0, SLOTS - 1);
      for (n = 0; n < SLOTS; n++) begin
         if (slot_used[s]) return s;
         s = (s + 1) % SLOTS;
      end
      return 0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic send_req(input bit op, input logic [SlotInBits-1:0] slot);
      int gap;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ReqDataBits'(slot);
      do @(posedge clock); while (!req_tready);
      expected_grants.push_back(grant_for_request(op, slot));
   endtask

   task automatic wait_all_granted();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_grants.size() > 0) @(posedge clock);
   endtask

   task automatic test_directed();
      repeat (3) send_req(OP_ALLOC, '0);
      send_req(OP_FREE, 11'd1);               // hint drops to 1
      send_req(OP_FREE, 11'd1);               // already free
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, 11'h7FF);             // out of range
      send_req(OP_FREE, SlotInBits'(SLOTS));  // first index out of range
      send_req(OP_FREE, SlotInBits'(SLOTS - 1));
      send_req(OP_FREE, 11'h555);
      send_req(OP_FREE, 11'h2AA);
      send_req(OP_FREE, 11'd0);
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, 11'h7FF);            // slot field ignored on alloc
   endtask

   task automatic test_random_traffic(input int count);
      int i;
      int pick;
      int alloc_pct;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         alloc_pct = (used_count > 700) ? 30 : 55;
         if (pick < alloc_pct || used_count == 0) begin
            send_req(OP_ALLOC, SlotInBits'($urandom_range(0, 2047)));
         end else if (pick < 90) begin
            send_req(OP_FREE, SlotInBits'(pick_used_slot()));
         end else begin
            send_req(OP_FREE, SlotInBits'($urandom_range(0, 2047)));
         end
      end
   endtask

   // result side: random stall bursts, none in the tail
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("result beat with nothing pending");
         end else begin
            checked_grant = expected_grants.pop_front();
            if (rsp_tdata[GrantBits-1:0] !== checked_grant.slot)
               report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                         rsp_tdata[GrantBits-1:0], checked_grant.slot));
            if (rsp_tuser !== checked_grant.no_free)
               report_mismatch($sformatf("no_free %b, expected %b",
                                         rsp_tuser, checked_grant.no_free));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ALLOC;
      rsp_tready = 1'b0;
      stall_left = 0;
      quiet_tail = 1'b0;
      mismatches = 0;
      next_hint  = 0;
      used_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_all_granted();
      test_random_traffic(534);
      quiet_tail = 1'b1;
      test_random_traffic(100);
      wait_all_granted();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
